>>> sv/chrs_pkg.sv
package chrs_pkg;

  localparam int RING_ENTRIES = 64;
  localparam int IDX_W = $clog2(RING_ENTRIES);
  localparam int CNT_W = (IDX_W + 1 > 3) ? IDX_W + 1 : 3;
  localparam int HASH_STEPS = 8;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  // prime 0x100000001b3 splits into a 9-bit low part and a shift by 40
  localparam logic [63:0] FNV_PRIME_LO = 64'h00000000000001B3;
  localparam int FNV_PRIME_SHIFT = 40;

  localparam logic [1:0] CMD_LOOKUP_KEY = 2'd0;
  localparam logic [1:0] CMD_LOOKUP_ID  = 2'd1;
  localparam logic [1:0] CMD_ADD        = 2'd2;
  localparam logic [1:0] CMD_ERASE      = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] server_id;
    logic [63:0] key_hash;
  } in_item_t;

  typedef struct packed {
    logic [15:0] selected_server;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic             load;
    logic             hash_en;
    logic             hash_hi;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
  } dp_stat_t;

  typedef struct packed {
    logic [63:0] position;
    logic [15:0] server;
  } entry_t;

endpackage

>>> sv/chrs_ctrl.sv
module chrs_ctrl import chrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HASH = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    in_ready = 1'b0;
    cmd = '0;
    cmd.rd_idx = cnt_r[IDX_W-1:0];
    cmd.hash_hi = cnt_r[0];
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_en = 1'b1;
        if (cnt_r == CNT_W'(HASH_STEPS - 1)) begin
          cnt_nxt = '0;
          state_nxt = S_SCAN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCAN: begin
        // read issued while below depth, compare follows in the cycle after each read
        if (cnt_r == CNT_W'(RING_ENTRIES)) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> sv/chrs_dp.sv
module chrs_dp import chrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  function automatic logic precedes(input logic [63:0] pa, input logic [15:0] sa,
                                    input logic [63:0] pb, input logic [15:0] sb);
    precedes = (pa != pb) ? (pa < pb) : (sa < sb);
  endfunction

  entry_t mem [RING_ENTRIES];
  logic [RING_ENTRIES-1:0] valid_r;

  logic [1:0]  op_r;
  logic [15:0] sid_r;
  logic [63:0] key_r;
  logic [63:0] h_r;

  entry_t           ent_q_r;
  logic             v_q_r;
  logic [IDX_W-1:0] idx_q_r;
  logic             cmp_vld_r;

  logic             all_found_r, ge_found_r, match_found_r, free_found_r;
  logic [63:0]      all_pos_r, ge_pos_r;
  logic [15:0]      all_srv_r, ge_srv_r;
  logic [IDX_W-1:0] match_idx_r, free_idx_r;

  logic             out_valid_r;
  out_item_t        out_data_r, res;

  logic [63:0] h_x, h_nxt, key_use;
  logic        wr_en;

  // one fnv-1a step: xor byte, multiply by prime mod 2^64
  always_comb begin
    h_x = h_r ^ {56'd0, (cmd.hash_hi ? sid_r[15:8] : sid_r[7:0])};
    h_nxt = (h_x * FNV_PRIME_LO) + (h_x << FNV_PRIME_SHIFT);
  end

  assign key_use = (op_r == CMD_LOOKUP_KEY) ? key_r : h_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_data.cmd;
      sid_r <= in_data.server_id;
      key_r <= in_data.key_hash;
      h_r <= FNV_BASIS;
    end else if (cmd.hash_en) begin
      h_r <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      ent_q_r <= mem[cmd.rd_idx];
      v_q_r <= valid_r[cmd.rd_idx];
      idx_q_r <= cmd.rd_idx;
    end
    if (wr_en) begin
      mem[free_idx_r] <= '{position: h_r, server: sid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      all_found_r <= 1'b0;
      ge_found_r <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmp_vld_r) begin
      if (v_q_r && (!all_found_r ||
          precedes(ent_q_r.position, ent_q_r.server, all_pos_r, all_srv_r))) begin
        all_found_r <= 1'b1;
        all_pos_r <= ent_q_r.position;
        all_srv_r <= ent_q_r.server;
      end
      if (v_q_r && ent_q_r.position >= key_use && (!ge_found_r ||
          precedes(ent_q_r.position, ent_q_r.server, ge_pos_r, ge_srv_r))) begin
        ge_found_r <= 1'b1;
        ge_pos_r <= ent_q_r.position;
        ge_srv_r <= ent_q_r.server;
      end
      if (v_q_r && ent_q_r.server == sid_r) begin
        match_found_r <= 1'b1;
        match_idx_r <= idx_q_r;
      end
      if (!v_q_r && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r <= idx_q_r;
      end
    end
  end

  always_comb begin
    res = '0;
    wr_en = 1'b0;
    case (op_r)
      CMD_LOOKUP_KEY, CMD_LOOKUP_ID: begin
        if (!all_found_r) begin
          res.status = ST_EMPTY;
        end else begin
          res.selected_server = ge_found_r ? ge_srv_r : all_srv_r;
        end
      end
      CMD_ADD: begin
        if (!match_found_r) begin
          if (free_found_r) begin
            wr_en = cmd.finish;
          end else begin
            res.status = ST_FULL;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.finish) begin
      if (wr_en) begin
        valid_r[free_idx_r] <= 1'b1;
      end else if (op_r == CMD_ERASE && match_found_r) begin
        valid_r[match_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign stat.out_valid = out_valid_r;

endmodule

>>> sv/consistent_hash_ring_selector_top.sv
// flow: accept, serial hash, ring scan, then finish; a new transaction is taken only after finish
// the ring scan reads one entry per cycle over the entry memory's single read port,
// after an 8-step serial fnv-1a hash
// reset: synchronous active-low rst_n clears all ring valid bits, the fsm and out_valid
module consistent_hash_ring_selector_top import chrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  chrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  chrs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second transaction while busy");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.selected_server == 16'd0)
    else $error("empty ring lookup returned a server");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.selected_server == 16'd0)
    else $error("refused add returned a server");

endmodule
